FILE: hw/rtl/pixel_cluster_accumulator_unit_assert.svh
// Assertion macros shared by the pixel cluster accumulator RTL.
`ifndef PIXEL_CLUSTER_ACCUMULATOR_UNIT_ASSERT_SVH
`define PIXEL_CLUSTER_ACCUMULATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define PCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PCA_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PCA_ASSERT(lbl, prop, msg)
`define PCA_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/pca_pkg.sv
// Package with constants and types of the pixel cluster accumulator.
`timescale 1ns / 1ps
package pca_pkg;
  localparam int unsigned MAX_PIXELS = 256;
  localparam int unsigned COORD_BITS = 10;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int unsigned SUM_W      = COORD_BITS + $clog2(MAX_PIXELS);
  localparam int unsigned CTR_W      = COORD_BITS + FRAC_BITS;
  localparam int unsigned DVD_W      = SUM_W + FRAC_BITS;
  localparam int unsigned DSTEP_W    = $clog2(DVD_W + 1);
  localparam int unsigned SCAN_GROUP = 16;
  localparam int unsigned SCAN_N     = (MAX_PIXELS + SCAN_GROUP - 1) / SCAN_GROUP;
  localparam int unsigned SCAN_W     = $clog2(SCAN_N + 1);
  localparam int unsigned HIT_W      = SCAN_N * SCAN_GROUP;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_NEAR   = 3'd1,
    CMD_SAME   = 3'd2,
    CMD_REPORT = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_LOAD,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } pixel_t;

  typedef struct packed {
    pixel_t pix;
    logic   shift;
  } cell_query_t;

  typedef struct packed {
    logic near;
    logic same;
  } cell_hit_t;
endpackage

FILE: hw/rtl/pca_if.sv
// Request and result channel interfaces of the pixel cluster accumulator.
`timescale 1ns / 1ps
interface pca_in_if import pca_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  coord_t           pixel_x;
  coord_t           pixel_y;
  modport source (output valid, command, pixel_x, pixel_y, input ready);
  modport sink (input valid, command, pixel_x, pixel_y, output ready);
endinterface

interface pca_out_if import pca_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             is_neighbour;
  logic             is_contained;
  logic             store_full;
  logic [CNT_W-1:0] pixel_count;
  coord_t           box_min_x;
  coord_t           box_min_y;
  coord_t           box_max_x;
  coord_t           box_max_y;
  logic [CTR_W-1:0] center_x;
  logic [CTR_W-1:0] center_y;
  modport source (output valid, is_neighbour, is_contained, store_full, pixel_count,
                  box_min_x, box_min_y, box_max_x, box_max_y, center_x, center_y,
                  input ready);
  modport sink (input valid, is_neighbour, is_contained, store_full, pixel_count,
                box_min_x, box_min_y, box_max_x, box_max_y, center_x, center_y,
                output ready);
endinterface

FILE: hw/rtl/pca_cell.sv
// One storage cell of the pixel chain with its neighbour and match compare.
`timescale 1ns / 1ps
module pca_cell import pca_pkg::*; (
  input  logic        clk_i,
  input  cell_query_t query_i,
  input  pixel_t      shift_in_i,
  input  logic        active_i,
  output pixel_t      shift_out_o,
  output cell_hit_t   hit_o
);
  pixel_t pix_q;
  logic   eq_x, eq_y, adj_x, adj_y;

  always_ff @(posedge clk_i) begin
    if (query_i.shift) begin
      pix_q <= shift_in_i;
    end
  end

  always_comb begin
    eq_x  = query_i.pix.x == pix_q.x;
    eq_y  = query_i.pix.y == pix_q.y;
    adj_x = ({1'b0, query_i.pix.x} == {1'b0, pix_q.x} + 1'b1) ||
            ({1'b0, pix_q.x} == {1'b0, query_i.pix.x} + 1'b1);
    adj_y = ({1'b0, query_i.pix.y} == {1'b0, pix_q.y} + 1'b1) ||
            ({1'b0, pix_q.y} == {1'b0, query_i.pix.y} + 1'b1);
    hit_o.same = active_i && eq_x && eq_y;
    hit_o.near = active_i && ((eq_x && eq_y) || (eq_x && adj_y) || (eq_y && adj_x));
  end

  assign shift_out_o = pix_q;
endmodule

FILE: hw/rtl/pca_divider.sv
// Bit-serial restoring divider for the centroid, one quotient bit a cycle.
`timescale 1ns / 1ps
`include "pixel_cluster_accumulator_unit_assert.svh"
module pca_divider import pca_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic [CTR_W-1:0] quot_o,
  output logic             done_o
);
  logic [DVD_W-1:0]   dvd_q, dvd_d;
  logic [CNT_W-1:0]   rem_q, rem_d, dsr_q;
  logic [DSTEP_W-1:0] step_q, step_d;
  logic [CNT_W:0]     trial, diff;
  logic               ge;

  assign done_o = step_q == DSTEP_W'(DVD_W);

  always_comb begin
    trial  = {rem_q, dvd_q[DVD_W-1]};
    diff   = trial - {1'b0, dsr_q};
    ge     = trial >= {1'b0, dsr_q};
    rem_d  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    dvd_d  = {dvd_q[DVD_W-2:0], ge};
    step_d = step_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= DSTEP_W'(DVD_W);
    end else if (load_i) begin
      step_q <= '0;
    end else if (!done_o) begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (!done_o) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign quot_o = dvd_q[CTR_W-1:0];

  `PCA_ASSERT(div_load_restarts_a, load_i |=> !done_o, "divider done right after load")
  `PCA_ASSERT(div_done_holds_a, done_o && !load_i |=> done_o, "divider left done without load")
  `PCA_ASSERT(div_step_range_a, step_q <= DSTEP_W'(DVD_W), "divider step count out of range")
endmodule

FILE: hw/rtl/pixel_cluster_accumulator_unit.sv
// Top level of the pixel cluster accumulator: cell chain, box, sums and centroid.
`timescale 1ns / 1ps
`include "pixel_cluster_accumulator_unit_assert.svh"
// Holds one cluster of up to MAX_PIXELS pixels in a chain of cells; an add shifts the
// new pixel into the head of the chain. Each request (add, neighbour test, contain test,
// report, clear) gives one result with both test flags, taken against the cluster as it
// stood before the request, plus count, bounding box and centroid (8 fraction bits, 0 when
// empty). From acceptance to the result a request passes a compare state, a divider load,
// then the bit-serial centroid divider (one quotient bit per cycle over the 26-bit scaled
// sum) while the cell hit flags are scanned SCAN_GROUP cells per cycle, and a done state.
// One request is in flight at a time; a new one is accepted while the previous result
// still waits on the output register. The store needs no clearing after reset.
module pixel_cluster_accumulator_unit import pca_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pca_in_if.sink     in_i,
  pca_out_if.source  out_o
);
  state_e           state_q, state_d;
  logic [CMD_W-1:0] cmd_q;
  pixel_t           qry_q;
  logic [CNT_W-1:0] count_q;
  coord_t           lo_x_q, lo_y_q, hi_x_q, hi_y_q;
  logic [SUM_W-1:0] sum_x_q, sum_y_q;
  logic             full_q;
  logic [HIT_W-1:0] near_vec_q, same_vec_q, near_bits, same_bits;
  logic             near_acc_q, same_acc_q;
  logic [SCAN_W-1:0] scan_q;
  logic             add_ok, scan_busy, div_load, div_done_x, div_done_y;
  logic [CTR_W-1:0] quot_x, quot_y;
  logic             out_valid_q, out_load;

  pixel_t      chain [MAX_PIXELS+1];
  cell_hit_t   hit [MAX_PIXELS];
  cell_query_t query;

  assign add_ok    = (cmd_q == CMD_ADD) && (count_q != CNT_W'(MAX_PIXELS));
  assign query.pix = qry_q;
  assign query.shift = (state_q == ST_CMP) && add_ok;
  assign chain[0]  = qry_q;
  assign scan_busy = scan_q != SCAN_W'(SCAN_N);
  assign div_load  = state_q == ST_LOAD;
  assign in_i.ready = state_q == ST_IDLE;

  for (genvar i = 0; i < MAX_PIXELS; i++) begin : g_cell
    pca_cell u_cell (
      .clk_i       (clk_i),
      .query_i     (query),
      .shift_in_i  (chain[i]),
      .active_i    (count_q > CNT_W'(i)),
      .shift_out_o (chain[i+1]),
      .hit_o       (hit[i])
    );
  end

  always_comb begin
    near_bits = '0;
    same_bits = '0;
    for (int i = 0; i < MAX_PIXELS; i++) begin
      near_bits[i] = hit[i].near;
      same_bits[i] = hit[i].same;
    end
  end

  pca_divider u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (div_load),
    .dividend_i ({sum_x_q, FRAC_BITS'(0)}),
    .divisor_i  (count_q),
    .quot_o     (quot_x),
    .done_o     (div_done_x)
  );

  pca_divider u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (div_load),
    .dividend_i ({sum_y_q, FRAC_BITS'(0)}),
    .divisor_i  (count_q),
    .quot_o     (quot_y),
    .done_o     (div_done_y)
  );

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_CMP;
      end
      ST_CMP:  state_d = ST_LOAD;
      ST_LOAD: state_d = ST_RUN;
      ST_RUN: begin
        if (div_done_x && div_done_y && !scan_busy) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      lo_x_q      <= '1;
      lo_y_q      <= '1;
      hi_x_q      <= '0;
      hi_y_q      <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      out_valid_q <= 1'b0;
      scan_q      <= SCAN_W'(SCAN_N);
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_CMP) begin
        scan_q <= '0;
        if (add_ok) begin
          count_q <= count_q + 1'b1;
          if (qry_q.x < lo_x_q) lo_x_q <= qry_q.x;
          if (qry_q.y < lo_y_q) lo_y_q <= qry_q.y;
          if (qry_q.x > hi_x_q) hi_x_q <= qry_q.x;
          if (qry_q.y > hi_y_q) hi_y_q <= qry_q.y;
          sum_x_q <= sum_x_q + SUM_W'(qry_q.x);
          sum_y_q <= sum_y_q + SUM_W'(qry_q.y);
        end else if (cmd_q == CMD_CLEAR) begin
          count_q <= '0;
          lo_x_q  <= '1;
          lo_y_q  <= '1;
          hi_x_q  <= '0;
          hi_y_q  <= '0;
          sum_x_q <= '0;
          sum_y_q <= '0;
        end
      end else if (scan_busy) begin
        scan_q <= scan_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q      <= in_i.command;
      qry_q      <= '{x: in_i.pixel_x, y: in_i.pixel_y};
      near_acc_q <= 1'b0;
      same_acc_q <= 1'b0;
    end
    if (state_q == ST_CMP) begin
      near_vec_q <= near_bits;
      same_vec_q <= same_bits;
      full_q     <= (cmd_q == CMD_ADD) && !add_ok;
    end else if (scan_busy) begin
      near_vec_q <= near_vec_q >> SCAN_GROUP;
      same_vec_q <= same_vec_q >> SCAN_GROUP;
      near_acc_q <= near_acc_q | (|near_vec_q[SCAN_GROUP-1:0]);
      same_acc_q <= same_acc_q | (|same_vec_q[SCAN_GROUP-1:0]);
    end
    if (out_load) begin
      out_o.is_neighbour <= near_acc_q;
      out_o.is_contained <= same_acc_q;
      out_o.store_full   <= full_q;
      out_o.pixel_count  <= count_q;
      out_o.box_min_x    <= lo_x_q;
      out_o.box_min_y    <= lo_y_q;
      out_o.box_max_x    <= hi_x_q;
      out_o.box_max_y    <= hi_y_q;
      out_o.center_x     <= (count_q == '0) ? '0 : quot_x;
      out_o.center_y     <= (count_q == '0) ? '0 : quot_y;
    end
  end

  assign out_o.valid = out_valid_q;

  `PCA_ASSERT(count_in_range_a, count_q <= CNT_W'(MAX_PIXELS), "pixel count beyond store")
  `PCA_ASSERT(accept_starts_a, in_i.valid && in_i.ready |=> state_q == ST_CMP, "no compare after accept")
  `PCA_ASSERT(same_implies_near_a, out_valid_q && out_o.is_contained |-> out_o.is_neighbour, "contained but not neighbour")
  `PCA_ASSERT(empty_centre_a, out_valid_q && out_o.pixel_count == '0 |-> out_o.center_x == '0 && out_o.center_y == '0, "empty cluster with centroid")
  `PCA_ASSERT_NORST(reset_quiet_a, !rst_ni |-> !out_valid_q, "result valid in reset")
endmodule
